// ===== design/piecewise_linear_transfer_table_assert.svh =====
// assertion macros used by the checker file of the transfer table
// depends on nothing; expects clock and reset in the scope of use
`ifndef PIECEWISE_LINEAR_TRANSFER_TABLE_ASSERT_SVH
`define PIECEWISE_LINEAR_TRANSFER_TABLE_ASSERT_SVH

// same-cycle implication
`define PLT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PLT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/plt_pkg.sv =====
// types and codes of the piecewise linear transfer table
// used by the top level, the divider and the checker
package plt_pkg;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_LOOKUP = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_TOO_FEW   = 3'd3;
   localparam logic [2:0] ST_RANGE     = 3'd4;

   localparam int NUM_W = 52;   // interpolation numerator
   localparam int DEN_W = 33;   // key span times 256
   localparam int QUO_W = 17;   // quotient magnitude bits

   typedef struct packed {
      logic [1:0]         command;
      logic signed [23:0] point_key;
      logic signed [23:0] point_value;
      logic signed [15:0] query;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [15:0] table_value;
      logic signed [15:0] range_begin;
      logic signed [15:0] range_end;
      logic [4:0]         point_count;
   } rsp_type;

   typedef struct packed {
      logic signed [23:0] key;
      logic signed [23:0] value;
   } entry_type;

endpackage

// ===== design/piecewise_linear_transfer_table.sv =====
// Piecewise linear transfer table: a sorted list of up to MAX_POINTS (key, value)
// points in one single-port-read synchronous memory, edited by insert, remove and
// clear and looked up at integer positions. One item is worked on at a time. After
// acceptance the memory is walked one entry at a time: insert and remove scan
// up to count entries and shift the tail one entry at a time; every command on a
// non-empty table then reads the first and last entry for the range. A table-mode
// lookup scans for its segment, runs two multiplies and the divider plt_div;
// identity lookups skip the scan, the multiplies and the divider.
// A finished result waits in the output register while the next item is taken.
// depends on plt_pkg and plt_div
module piecewise_linear_transfer_table #(
   parameter int MAX_POINTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  plt_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output plt_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic             csr_wdata
);
   import plt_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_SCAN, S_SCAN_CHK, S_SH_RD, S_SH_WR, S_PUT,
      S_RB_RD, S_RB_CHK, S_RE_CHK, S_POST, S_LK_RD, S_LK_CHK,
      S_MUL_A, S_MUL_B, S_SUM, S_DIV_GO, S_DIV_WAIT, S_DONE
   } state_type;

   state_type          state_ff;
   logic [1:0]         cmd_ff;
   logic signed [23:0] key_ff;
   logic signed [23:0] val_ff;
   logic signed [15:0] qry_ff;
   logic               mode_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      idx_ff;
   logic [CW-1:0]      pos_ff;
   logic [2:0]         status_ff;
   logic signed [15:0] result_ff;
   logic signed [15:0] rb_ff;
   logic signed [15:0] re_ff;
   logic signed [23:0] first_val_ff;
   logic signed [23:0] k0_ff, v0_ff, k1_ff, v1_ff;
   logic signed [NUM_W-1:0] prod_a_ff, prod_b_ff, num_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   entry_type mem [MAX_POINTS];
   entry_type rd_data_ff;
   logic          mem_re, mem_we;
   logic [AW-1:0] mem_ra, mem_wa;
   entry_type     mem_wd;

   logic               full;
   logic               is_insert;
   logic [CW-1:0]      src_idx;
   logic [CW-1:0]      last_idx;
   logic signed [23:0] xs;
   logic signed [25:0] k0e, k1e, v0e, v1e, xse, dk, dv, dt;
   logic [24:0]        fv_mag;
   logic [24:0]        fv_trunc;
   logic               div_start, div_done;
   logic signed [15:0] div_quot;

   assign full      = count_ff == CW'(MAX_POINTS);
   assign is_insert = cmd_ff == CMD_INSERT;
   assign src_idx   = is_insert ? idx_ff - 1'b1 : idx_ff + 1'b1;
   assign last_idx  = count_ff - 1'b1;
   assign xs        = {qry_ff, 8'b0};

   assign k0e = {{2{k0_ff[23]}}, k0_ff};
   assign k1e = {{2{k1_ff[23]}}, k1_ff};
   assign v0e = {{2{v0_ff[23]}}, v0_ff};
   assign v1e = {{2{v1_ff[23]}}, v1_ff};
   assign xse = {{2{xs[23]}}, xs};
   assign dk  = k1e - k0e;
   assign dv  = v1e - v0e;
   assign dt  = xse - k0e;

   // trunc toward zero of the first value over 256
   assign fv_mag   = first_val_ff[23] ? (~{first_val_ff[23], first_val_ff} + 1'b1)
                                      : {first_val_ff[23], first_val_ff};
   assign fv_trunc = first_val_ff[23] ? (~(fv_mag >> 8) + 1'b1) : (fv_mag >> 8);

   assign div_start = state_ff == S_DIV_GO;

   plt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (num_ff),
      .denom ({dk[24:0], 8'b0}),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      mem_re = 1'b0;
      mem_ra = '0;
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = '{key: key_ff, value: val_ff};
      case (state_ff)
         S_SCAN: begin
            if (idx_ff != count_ff) begin
               mem_re = 1'b1;
               mem_ra = idx_ff[AW-1:0];
            end
         end
         S_SCAN_CHK: begin
            // replace the value of an existing key in place
            if (is_insert && rd_data_ff.key == key_ff) begin
               mem_we = 1'b1;
               mem_wa = idx_ff[AW-1:0];
            end
         end
         S_SH_RD: begin
            mem_re = 1'b1;
            mem_ra = src_idx[AW-1:0];
         end
         S_SH_WR: begin
            mem_we = 1'b1;
            mem_wa = idx_ff[AW-1:0];
            mem_wd = rd_data_ff;
         end
         S_PUT: begin
            mem_we = 1'b1;
            mem_wa = pos_ff[AW-1:0];
         end
         S_RB_RD: begin
            mem_re = count_ff != '0;
            mem_ra = '0;
         end
         S_RB_CHK: begin
            mem_re = 1'b1;
            mem_ra = last_idx[AW-1:0];
         end
         S_LK_RD: begin
            mem_re = 1'b1;
            mem_ra = idx_ff[AW-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         // the done state reloads the output register itself
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff    <= req_payload.command;
                  key_ff    <= req_payload.point_key;
                  val_ff    <= req_payload.point_value;
                  qry_ff    <= req_payload.query;
                  status_ff <= ST_OK;
                  result_ff <= '0;
                  idx_ff    <= '0;
                  unique case (req_payload.command)
                     CMD_INSERT, CMD_REMOVE: state_ff <= S_SCAN;
                     CMD_CLEAR: begin
                        count_ff <= '0;
                        state_ff <= S_RB_RD;
                     end
                     default: state_ff <= S_RB_RD;
                  endcase
               end
            end
            S_SCAN: begin
               if (idx_ff == count_ff) begin
                  if (!is_insert) begin
                     status_ff <= ST_NOT_FOUND;
                     state_ff  <= S_RB_RD;
                  end else if (full) begin
                     status_ff <= ST_FULL;
                     state_ff  <= S_RB_RD;
                  end else begin
                     pos_ff   <= count_ff;
                     state_ff <= S_PUT;
                  end
               end else begin
                  state_ff <= S_SCAN_CHK;
               end
            end
            S_SCAN_CHK: begin
               if (is_insert) begin
                  if (rd_data_ff.key < key_ff) begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_SCAN;
                  end else if (rd_data_ff.key == key_ff) begin
                     state_ff <= S_RB_RD;
                  end else if (full) begin
                     status_ff <= ST_FULL;
                     state_ff  <= S_RB_RD;
                  end else begin
                     pos_ff   <= idx_ff;
                     idx_ff   <= count_ff;
                     state_ff <= S_SH_RD;
                  end
               end else if (rd_data_ff.key == key_ff) begin
                  pos_ff <= idx_ff;
                  if (idx_ff + 1'b1 < count_ff) begin
                     state_ff <= S_SH_RD;
                  end else begin
                     count_ff <= count_ff - 1'b1;
                     state_ff <= S_RB_RD;
                  end
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_SCAN;
               end
            end
            S_SH_RD: state_ff <= S_SH_WR;
            S_SH_WR: begin
               if (is_insert) begin
                  idx_ff   <= idx_ff - 1'b1;
                  state_ff <= (idx_ff - 1'b1 == pos_ff) ? S_PUT : S_SH_RD;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  if ((CW+1)'(idx_ff) + (CW+1)'(2) < (CW+1)'(count_ff)) begin
                     state_ff <= S_SH_RD;
                  end else begin
                     count_ff <= count_ff - 1'b1;
                     state_ff <= S_RB_RD;
                  end
               end
            end
            S_PUT: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= S_RB_RD;
            end
            S_RB_RD: begin
               if (count_ff == '0) begin
                  rb_ff    <= '0;
                  re_ff    <= '0;
                  state_ff <= S_POST;
               end else begin
                  state_ff <= S_RB_CHK;
               end
            end
            S_RB_CHK: begin
               rb_ff        <= rd_data_ff.key[23:8];
               first_val_ff <= rd_data_ff.value;
               state_ff     <= S_RE_CHK;
            end
            S_RE_CHK: begin
               re_ff    <= rd_data_ff.key[23:8];
               state_ff <= S_POST;
            end
            S_POST: begin
               state_ff <= S_DONE;
               if (cmd_ff == CMD_LOOKUP) begin
                  if (count_ff < CW'(2)) begin
                     status_ff <= ST_TOO_FEW;
                  end else if (qry_ff < rb_ff || qry_ff > re_ff) begin
                     status_ff <= ST_RANGE;
                  end else if (!mode_ff) begin
                     result_ff <= qry_ff;
                  end else if (qry_ff == rb_ff) begin
                     result_ff <= fv_trunc[15:0];
                  end else begin
                     idx_ff   <= '0;
                     state_ff <= S_LK_RD;
                  end
               end
            end
            S_LK_RD: state_ff <= S_LK_CHK;
            S_LK_CHK: begin
               if (idx_ff != '0 && xs > k0_ff && xs <= rd_data_ff.key) begin
                  k1_ff    <= rd_data_ff.key;
                  v1_ff    <= rd_data_ff.value;
                  state_ff <= S_MUL_A;
               end else begin
                  k0_ff <= rd_data_ff.key;
                  v0_ff <= rd_data_ff.value;
                  if (idx_ff == last_idx) begin
                     state_ff <= S_DONE;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_LK_RD;
                  end
               end
            end
            S_MUL_A: begin
               prod_a_ff <= v0e * dk;
               state_ff  <= S_MUL_B;
            end
            S_MUL_B: begin
               prod_b_ff <= dv * dt;
               state_ff  <= S_SUM;
            end
            S_SUM: begin
               num_ff   <= prod_a_ff + prod_b_ff;
               state_ff <= S_DIV_GO;
            end
            S_DIV_GO: state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: begin
               if (div_done) begin
                  result_ff <= div_quot;
                  state_ff  <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '{status: status_ff, table_value: result_ff,
                                    range_begin: rb_ff, range_end: re_ff,
                                    point_count: 5'(count_ff)};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready   = state_ff == S_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== design/plt_div.sv =====
// signed restoring divider, one quotient bit per cycle
// depends on plt_pkg for the operand widths
module plt_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [plt_pkg::NUM_W-1:0]     numer,
   input  logic [plt_pkg::DEN_W-1:0]            denom,
   output logic                                 done,
   output logic signed [15:0]                   quot
);
   import plt_pkg::*;

   localparam int REM_W = NUM_W - 1;
   localparam int DSH_W = DEN_W + QUO_W - 1;

   logic [NUM_W-1:0] mag;
   logic [REM_W-1:0] rem_ff;
   logic [DSH_W-1:0] dsh_ff;
   logic [QUO_W-1:0] q_ff;
   logic [QUO_W-1:0] q_signed;
   logic [4:0]       cnt_ff;
   logic             neg_ff;
   logic             busy_ff;
   logic             done_ff;
   logic             ge;

   assign mag = numer[NUM_W-1] ? (~numer + 1'b1) : numer;
   assign ge  = rem_ff >= REM_W'(dsh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            rem_ff  <= mag[REM_W-1:0];
            dsh_ff  <= {denom, {(QUO_W-1){1'b0}}};
            q_ff    <= '0;
            neg_ff  <= numer[NUM_W-1];
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (ge) begin
               rem_ff <= rem_ff - REM_W'(dsh_ff);
            end
            q_ff   <= {q_ff[QUO_W-2:0], ge};
            dsh_ff <= dsh_ff >> 1;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(QUO_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign q_signed = neg_ff ? (~q_ff + 1'b1) : q_ff;
   assign quot     = q_signed[15:0];
   assign done     = done_ff;

endmodule

// ===== design/plt_checker.sv =====
// port-level checks of the transfer table's result channel, bound to the top level
// depends on plt_pkg and piecewise_linear_transfer_table_assert.svh
`include "piecewise_linear_transfer_table_assert.svh"

module plt_checker #(
   parameter int MAX_POINTS = 16
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input plt_pkg::rsp_type rsp_payload
);
   import plt_pkg::*;

   `PLT_ASSERT_NOW(a_count_bound, rsp_valid, int'(rsp_payload.point_count) <= MAX_POINTS, "point count above table size")
   `PLT_ASSERT_NOW(a_fail_zero, rsp_valid && rsp_payload.status != ST_OK, rsp_payload.table_value == 16'sd0, "failed command with nonzero value")
   `PLT_ASSERT_NOW(a_empty_range, rsp_valid && rsp_payload.point_count == 5'd0, rsp_payload.range_begin == 16'sd0 && rsp_payload.range_end == 16'sd0, "empty table with nonzero range")
   `PLT_ASSERT_NOW(a_too_few, rsp_valid && rsp_payload.status == ST_TOO_FEW, rsp_payload.point_count < 5'd2, "too few points flagged with two or more")
   `PLT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "result dropped or changed before transfer")

endmodule

bind piecewise_linear_transfer_table plt_checker #(.MAX_POINTS(MAX_POINTS)) u_plt_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ===== bench/tb_piecewise_linear_transfer_table.sv =====
// testbench for piecewise_linear_transfer_table: directed table then random command mixes
// results are checked against an in-bench interpolation predictor or typed expectations; needs plt_pkg
`timescale 1ns / 1ps

module tb_piecewise_linear_transfer_table;
   import plt_pkg::*;

   localparam int NPTS = 16;
   localparam int DRAIN = 80;   // margin for the slowest command to finish

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic    csr_we = 1'b0;
   logic    csr_wdata = 1'b0;

   piecewise_linear_transfer_table #(.MAX_POINTS(NPTS)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state
   logic signed [23:0] pt_key [NPTS];
   logic signed [23:0] pt_val [NPTS];
   int      pt_count = 0;
   bit      interp_mode = 1'b0;
   rsp_type pending_rsp [$];
   int      fail_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;

   function automatic logic signed [15:0] key_floor(logic signed [23:0] k);
      return 16'(k >>> 8);
   endfunction

   function automatic int segment_value(int x);
      longint xs, k0, k1, v0, v1, dk, num;
      xs = longint'(x) * 256;
      if (x == int'(key_floor(pt_key[0]))) return int'(pt_val[0]) / 256;
      for (int i = 1; i < pt_count; i++) begin
         k0 = pt_key[i-1];
         k1 = pt_key[i];
         if (xs > k0 && xs <= k1) begin
            v0 = pt_val[i-1];
            v1 = pt_val[i];
            dk = k1 - k0;
            num = v0 * dk + (v1 - v0) * (xs - k0);
            return int'(num / (dk * 256));
         end
      end
      return 0;
   endfunction

   function automatic rsp_type apply_command(req_type r);
      rsp_type o;
      int pos;
      o = '0;
      o.status = ST_OK;
      case (r.command)
         CMD_INSERT: begin
            pos = 0;
            while (pos < pt_count && pt_key[pos] < r.point_key) pos++;
            if (pos < pt_count && pt_key[pos] == r.point_key) pt_val[pos] = r.point_value;
            else if (pt_count >= NPTS) o.status = ST_FULL;
            else begin
               for (int i = pt_count; i > pos; i--) begin
                  pt_key[i] = pt_key[i-1];
                  pt_val[i] = pt_val[i-1];
               end
               pt_key[pos] = r.point_key;
               pt_val[pos] = r.point_value;
               pt_count++;
            end
         end
         CMD_REMOVE: begin
            pos = 0;
            while (pos < pt_count && pt_key[pos] != r.point_key) pos++;
            if (pos >= pt_count) o.status = ST_NOT_FOUND;
            else begin
               for (int i = pos; i + 1 < pt_count; i++) begin
                  pt_key[i] = pt_key[i+1];
                  pt_val[i] = pt_val[i+1];
               end
               pt_count--;
            end
         end
         CMD_CLEAR: pt_count = 0;
         default: ;
      endcase
      if (pt_count > 0) begin
         o.range_begin = key_floor(pt_key[0]);
         o.range_end = key_floor(pt_key[pt_count-1]);
      end
      if (r.command == CMD_LOOKUP) begin
         if (pt_count < 2) o.status = ST_TOO_FEW;
         else if (r.query < o.range_begin || r.query > o.range_end) o.status = ST_RANGE;
         else o.table_value = interp_mode ? 16'(segment_value(int'(r.query))) : r.query;
      end
      o.point_count = 5'(pt_count);
      return o;
   endfunction

   // drive one transfer; expectation is typed in when use_typed is set
   task automatic send_item(req_type r, bit use_typed = 0, rsp_type typed = '0);
      rsp_type p;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      p = apply_command(r);
      pending_rsp = {pending_rsp, (use_typed ? typed : p)};
   endtask

   task automatic write_mode(bit m);
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (DRAIN) @(posedge clock);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(negedge clock);
      csr_we <= 1'b0;
      interp_mode = m;
   endtask

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result transfer %p", rsp_payload);
            fail_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_payload.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_payload.status);
               fail_count++;
            end
            if (rsp_payload.table_value !== e.table_value) begin
               $error("table_value: expected %0d, got %0d", e.table_value,
                      rsp_payload.table_value);
               fail_count++;
            end
            if (rsp_payload.range_begin !== e.range_begin) begin
               $error("range_begin: expected %0d, got %0d", e.range_begin,
                      rsp_payload.range_begin);
               fail_count++;
            end
            if (rsp_payload.range_end !== e.range_end) begin
               $error("range_end: expected %0d, got %0d", e.range_end, rsp_payload.range_end);
               fail_count++;
            end
            if (rsp_payload.point_count !== e.point_count) begin
               $error("point_count: expected %0d, got %0d", e.point_count,
                      rsp_payload.point_count);
               fail_count++;
            end
         end
      end
   end

   typedef struct {
      req_type r;
      bit      typed;
      rsp_type e;
   } stim_row_type;

   localparam int NROWS = 20;
   stim_row_type dir_rows [NROWS] = '{
      '{'{CMD_LOOKUP, 24'sd0, 24'sd0, 16'sd0}, 1, '{ST_TOO_FEW, 16'sd0, 16'sd0, 16'sd0, 5'd0}},
      '{'{CMD_REMOVE, 24'sd5, 24'sd0, 16'sd0}, 1, '{ST_NOT_FOUND, 16'sd0, 16'sd0, 16'sd0, 5'd0}},
      '{'{CMD_INSERT, -24'sd8388608, -24'sd8388608, 16'sd0}, 1,
        '{ST_OK, 16'sd0, -16'sd32768, -16'sd32768, 5'd1}},
      '{'{CMD_LOOKUP, 24'sd0, 24'sd0, -16'sd32768}, 1,
        '{ST_TOO_FEW, 16'sd0, -16'sd32768, -16'sd32768, 5'd1}},
      '{'{CMD_INSERT, 24'sd8388607, 24'sd8388607, 16'sd0}, 1,
        '{ST_OK, 16'sd0, -16'sd32768, 16'sd32767, 5'd2}},
      '{'{CMD_LOOKUP, 24'sd0, 24'sd0, -16'sd32768}, 1,
        '{ST_OK, -16'sd32768, -16'sd32768, 16'sd32767, 5'd2}},
      '{'{CMD_LOOKUP, 24'sd0, 24'sd0, 16'sd32767}, 0, '0},
      '{'{CMD_LOOKUP, 24'sd0, 24'sd0, 16'sd0}, 0, '0},
      '{'{CMD_INSERT, 24'sd0, 24'sd25600, 16'sd0}, 0, '0},
      '{'{CMD_INSERT, 24'sd0, -24'sd25600, 16'sd0}, 0, '0},   // key present: value replaced
      '{'{CMD_LOOKUP, 24'sd0, 24'sd0, 16'sd0}, 0, '0},
      '{'{CMD_LOOKUP, 24'sd0, 24'sd0, -16'sd1}, 0, '0},
      '{'{CMD_REMOVE, 24'sd0, 24'sd0, 16'sd0}, 0, '0},
      '{'{CMD_CLEAR, 24'sd0, 24'sd0, 16'sd0}, 1, '{ST_OK, 16'sd0, 16'sd0, 16'sd0, 5'd0}},
      '{'{CMD_INSERT, -24'sd384, 24'sd1000, 16'sd0}, 0, '0},
      '{'{CMD_INSERT, 24'sd640, -24'sd1000, 16'sd0}, 0, '0},
      '{'{CMD_LOOKUP, 24'sd0, 24'sd0, -16'sd2}, 0, '0},         // range start, negative floor
      '{'{CMD_LOOKUP, 24'sd0, 24'sd0, 16'sd2}, 0, '0},
      '{'{CMD_LOOKUP, 24'sd0, 24'sd0, 16'sd3}, 1, '{ST_RANGE, 16'sd0, -16'sd2, 16'sd2, 5'd2}},
      '{'{CMD_LOOKUP, 24'sd0, 24'sd0, -16'sd3}, 1, '{ST_RANGE, 16'sd0, -16'sd2, 16'sd2, 5'd2}}
   };

   function automatic logic signed [23:0] rand_key(int span_sel, int base);
      if (span_sel == 0) return 24'($urandom);
      return 24'(base + int'($urandom_range(4000)));
   endfunction

   function automatic logic signed [15:0] rand_query();
      int lo, hi;
      if (pt_count < 2 || $urandom_range(9) == 0) return 16'($urandom);
      lo = int'(key_floor(pt_key[0]));
      hi = int'(key_floor(pt_key[pt_count-1]));
      return 16'(lo + int'($urandom_range(hi - lo)));
   endfunction

   initial begin
      req_type r;
      int sent, span_sel, base, n;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_mode(1'b1);
      for (int i = 0; i < NROWS; i++) send_item(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].e);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph / 2)
            0: begin send_idle_pct = 6;  recv_idle_pct = 82; end
            1: begin send_idle_pct = 82; recv_idle_pct = 6;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         write_mode(ph % 2 == 1);
         sent = 0;
         while (sent < 305) begin
            // one table build then lookups and edits
            span_sel = $urandom_range(3);
            base = int'($urandom_range(8000)) * 2000 - 8000000;
            if ($urandom_range(3) != 0) begin
               r = '0;
               r.command = CMD_CLEAR;
               send_item(r);
               sent++;
            end
            n = $urandom_range(2, 19);
            for (int i = 0; i < n; i++) begin
               r.command = CMD_INSERT;
               r.point_key = rand_key(span_sel, base);
               r.point_value = 24'($urandom);
               r.query = 16'($urandom);
               send_item(r);
               sent++;
            end
            n = $urandom_range(4, 14);
            for (int i = 0; i < n; i++) begin
               r.point_value = 24'($urandom);
               r.query = rand_query();
               case ($urandom_range(9))
                  0: begin
                     r.command = CMD_REMOVE;
                     r.point_key = (pt_count > 0 && $urandom_range(1)) ?
                        pt_key[$urandom_range(pt_count - 1)] : rand_key(span_sel, base);
                  end
                  1: begin
                     r.command = CMD_INSERT;
                     r.point_key = (pt_count > 0) ? pt_key[$urandom_range(pt_count - 1)]
                                                  : rand_key(span_sel, base);
                  end
                  2: begin
                     r.command = 2'($urandom);
                     r.point_key = 24'($urandom);
                     r.query = 16'($urandom);
                  end
                  default: begin
                     r.command = CMD_LOOKUP;
                     r.point_key = 24'($urandom);
                  end
               endcase
               send_item(r);
               sent++;
            end
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
